### design/gbfs_pkg.sv
// ----------------------------------------------------------------------------
// gbfs_pkg: shared types and constants of the grid path search core
// Holds the word formats of the item and result channels, the codes of the
// operations and configuration registers, and the link between top and engine.
// ----------------------------------------------------------------------------
package gbfs_pkg;

  // Default storage size of the maze.
  localparam int MAX_ROWS_DEF = 64;
  localparam int MAX_COLS_DEF = 64;

  // Field widths fixed by the channel formats.
  localparam int COORD_W = 6;
  localparam int SIZE_W  = 7;
  localparam int DIST_W  = 12;

  // Largest distance that the result can carry; longer paths saturate.
  localparam int unsigned DIST_MAX = 4095;

  // Size registers after reset.
  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

  // Operation codes of an item word.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_SOLVE = 1'b1;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;

  // One item word.
  typedef struct packed {
    logic               operation;
    logic [COORD_W-1:0] cell_row;
    logic [COORD_W-1:0] cell_col;
    logic               cell_open;
    logic [COORD_W-1:0] src_row;
    logic [COORD_W-1:0] src_col;
    logic [COORD_W-1:0] dst_row;
    logic [COORD_W-1:0] dst_col;
  } gbfs_item_t;

  // One result word.
  typedef struct packed {
    logic              reachable;
    logic [DIST_W-1:0] distance;
  } gbfs_result_t;

  // Command from the top level to the search engine.
  typedef struct packed {
    logic              load;
    logic              run;
    gbfs_item_t        item;
    logic [SIZE_W-1:0] rows;
    logic [SIZE_W-1:0] cols;
  } gbfs_cmd_t;

  // Status from the search engine to the top level.
  typedef struct packed {
    logic         busy;
    logic         done;
    gbfs_result_t result;
  } gbfs_status_t;

endpackage

### design/gbfs_engine.sv
// ----------------------------------------------------------------------------
// gbfs_engine: maze store and breadth-first search sequencer
// Holds the maze, the distance store and the cell queue as memories, and walks
// the queue one neighbour at a time under a small one-hot sequencer.
// ----------------------------------------------------------------------------
module gbfs_engine #(
  parameter int MAX_ROWS = gbfs_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = gbfs_pkg::MAX_COLS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  gbfs_pkg::gbfs_cmd_t  cmd,
  input  logic                 res_full,
  output gbfs_pkg::gbfs_status_t status
);

  // Address and storage geometry.
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int AW    = RW + CW;
  localparam int DEPTH = MAX_ROWS * (1 << CW);
  localparam int QD    = MAX_ROWS * MAX_COLS;
  localparam int QAW   = (QD > 1) ? $clog2(QD) : 1;
  localparam int DW    = (QD > 1) ? $clog2(QD) : 1;
  localparam int XW    = (RW > CW) ? RW : CW;
  localparam int CMPW  = ((XW > gbfs_pkg::SIZE_W) ? XW : gbfs_pkg::SIZE_W) + 1;
  localparam int QEW   = AW + DW;
  localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_CLEAR = 8'b0000_0010,
    ST_SEED  = 8'b0000_0100,
    ST_POP   = 8'b0000_1000,
    ST_NRD   = 8'b0001_0000,
    ST_NCHK  = 8'b0010_0000,
    ST_FRD   = 8'b0100_0000,
    ST_FIN   = 8'b1000_0000
  } state_t;

  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_DOWN  = 2'd2,
    DIR_LEFT  = 2'd3
  } dir_t;

  // Memories.
  logic            maze_mem [DEPTH];
  logic [DW:0]     dist_mem [DEPTH];
  logic [QEW-1:0]  queue_mem [QD];

  // Control registers.
  state_t                      state, state_next;
  dir_t                        dir;
  logic [AW-1:0]               clr;
  logic [QAW:0]                head, tail;
  logic [gbfs_pkg::SIZE_W-1:0] nr, nc;
  logic                        bad;

  // Payload registers.
  logic [RW-1:0]  src_r, dst_r;
  logic [CW-1:0]  src_c, dst_c;
  logic [AW-1:0]  naddr;
  logic           mz_rd;
  logic [DW:0]    ds_rd;
  logic [QEW-1:0] q_rd;

  // Decoded current queue entry and its neighbour.
  logic [RW-1:0] cur_r, nb_r;
  logic [CW-1:0] cur_c, nb_c;
  logic [DW-1:0] cur_d, nd;
  logic          nb_ok, fresh, more_nrd, more_nchk;
  logic [AW-1:0] nb_addr, src_addr, dst_addr;

  // Size clamp and endpoint check for a new solve.
  logic [gbfs_pkg::SIZE_W-1:0] nr_in, nc_in;
  logic                        bad_in;

  // Memory write and read controls.
  logic           dw_en;
  logic [AW-1:0]  dw_addr;
  logic [DW:0]    dw_data;
  logic           qw_en;
  logic [QAW-1:0] qw_addr;
  logic [QEW-1:0] qw_data;
  logic           dr_en;
  logic [AW-1:0]  dr_addr;
  logic           load_ok;
  logic [AW-1:0]  load_addr;

  // Clamp the configured size into the storage and check the endpoints.
  always_comb begin
    if (cmd.rows == '0) begin
      nr_in = gbfs_pkg::SIZE_W'(1);
    end else if (32'(cmd.rows) > MAX_ROWS) begin
      nr_in = gbfs_pkg::SIZE_W'(MAX_ROWS);
    end else begin
      nr_in = cmd.rows;
    end
    if (cmd.cols == '0) begin
      nc_in = gbfs_pkg::SIZE_W'(1);
    end else if (32'(cmd.cols) > MAX_COLS) begin
      nc_in = gbfs_pkg::SIZE_W'(MAX_COLS);
    end else begin
      nc_in = cmd.cols;
    end
    bad_in = ({1'b0, cmd.item.src_row} >= nr_in) || ({1'b0, cmd.item.src_col} >= nc_in) ||
             ({1'b0, cmd.item.dst_row} >= nr_in) || ({1'b0, cmd.item.dst_col} >= nc_in);
  end

  // Maze cell writes outside the storage are dropped.
  assign load_ok   = cmd.load && (32'(cmd.item.cell_row) < MAX_ROWS) &&
                     (32'(cmd.item.cell_col) < MAX_COLS);
  assign load_addr = {RW'(cmd.item.cell_row), CW'(cmd.item.cell_col)};

  // Current queue entry: cell address and its distance.
  assign cur_r = q_rd[QEW-1 -: RW];
  assign cur_c = q_rd[DW+CW-1 -: CW];
  assign cur_d = q_rd[DW-1:0];
  assign nd    = cur_d + DW'(1);

  // The neighbour in the direction under test, and whether it lies in the area.
  always_comb begin
    nb_r  = cur_r;
    nb_c  = cur_c;
    nb_ok = 1'b0;
    unique case (dir)
      DIR_UP: begin
        nb_r  = cur_r - RW'(1);
        nb_ok = (cur_r != '0);
      end
      DIR_RIGHT: begin
        nb_c  = cur_c + CW'(1);
        nb_ok = (CMPW'(cur_c) + CMPW'(1)) < CMPW'(nc);
      end
      DIR_DOWN: begin
        nb_r  = cur_r + RW'(1);
        nb_ok = (CMPW'(cur_r) + CMPW'(1)) < CMPW'(nr);
      end
      DIR_LEFT: begin
        nb_c  = cur_c - CW'(1);
        nb_ok = (cur_c != '0);
      end
      default: begin
        nb_ok = 1'b0;
      end
    endcase
  end

  assign nb_addr   = {nb_r, nb_c};
  assign src_addr  = {src_r, src_c};
  assign dst_addr  = {dst_r, dst_c};
  assign fresh     = mz_rd && !ds_rd[DW];
  assign more_nrd  = (head != tail);
  assign more_nchk = (head != (tail + (QAW+1)'(fresh)));

  // Memory port selection per state.
  always_comb begin
    dw_en   = 1'b0;
    dw_addr = naddr;
    dw_data = {1'b1, nd};
    qw_en   = 1'b0;
    qw_addr = tail[QAW-1:0];
    qw_data = {naddr, nd};
    dr_en   = 1'b0;
    dr_addr = nb_addr;
    unique case (state)
      ST_CLEAR: begin
        dw_en   = 1'b1;
        dw_addr = clr;
        dw_data = '0;
      end
      ST_SEED: begin
        dw_en   = 1'b1;
        dw_addr = src_addr;
        dw_data = {1'b1, DW'(0)};
        qw_en   = 1'b1;
        qw_addr = '0;
        qw_data = {src_addr, DW'(0)};
      end
      ST_NRD: begin
        dr_en = nb_ok;
      end
      ST_NCHK: begin
        dw_en = fresh;
        qw_en = fresh;
      end
      ST_FRD: begin
        dr_en   = 1'b1;
        dr_addr = dst_addr;
      end
      default: begin
        dw_en = 1'b0;
      end
    endcase
  end

  // Maze store: written by load words, read for each neighbour inside the area and for the destination.
  always_ff @(posedge clk) begin
    if (load_ok) begin
      maze_mem[load_addr] <= cmd.item.cell_open;
    end
    if (dr_en) begin
      mz_rd <= maze_mem[dr_addr];
    end
  end

  // Distance store: a visited flag over the distance of each cell.
  always_ff @(posedge clk) begin
    if (dw_en) begin
      dist_mem[dw_addr] <= dw_data;
    end
    if (dr_en) begin
      ds_rd <= dist_mem[dr_addr];
    end
  end

  // Cell queue: each entry holds a cell address and its distance.
  always_ff @(posedge clk) begin
    if (qw_en) begin
      queue_mem[qw_addr] <= qw_data;
    end
    if (state == ST_POP) begin
      q_rd <= queue_mem[head[QAW-1:0]];
    end
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.run) begin
          state_next = bad_in ? ST_FIN : ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        if (clr == CLR_LAST) begin
          state_next = ST_SEED;
        end
      end
      ST_SEED: begin
        state_next = ST_POP;
      end
      ST_POP: begin
        state_next = ST_NRD;
      end
      ST_NRD: begin
        if (nb_ok) begin
          state_next = ST_NCHK;
        end else if (dir == DIR_LEFT) begin
          state_next = more_nrd ? ST_POP : ST_FRD;
        end
      end
      ST_NCHK: begin
        if (dir == DIR_LEFT) begin
          state_next = more_nchk ? ST_POP : ST_FRD;
        end else begin
          state_next = ST_NRD;
        end
      end
      ST_FRD: begin
        state_next = ST_FIN;
      end
      ST_FIN: begin
        if (!res_full) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Sequencer registers, counters and pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      dir   <= DIR_UP;
      clr   <= '0;
      head  <= '0;
      tail  <= '0;
      nr    <= gbfs_pkg::SIZE_RESET;
      nc    <= gbfs_pkg::SIZE_RESET;
      bad   <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          if (cmd.run) begin
            nr  <= nr_in;
            nc  <= nc_in;
            bad <= bad_in;
            clr <= '0;
          end
        end
        ST_CLEAR: begin
          clr <= clr + AW'(1);
        end
        ST_SEED: begin
          head <= '0;
          tail <= (QAW+1)'(1);
        end
        ST_POP: begin
          head <= head + (QAW+1)'(1);
          dir  <= DIR_UP;
        end
        ST_NRD: begin
          if (!nb_ok && dir != DIR_LEFT) begin
            dir <= dir_t'(dir + 2'd1);
          end
        end
        ST_NCHK: begin
          if (fresh) begin
            tail <= tail + (QAW+1)'(1);
          end
          if (dir != DIR_LEFT) begin
            dir <= dir_t'(dir + 2'd1);
          end
        end
        default: begin
          dir <= dir;
        end
      endcase
    end
  end

  // Endpoints and neighbour address are payload and need no reset.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && cmd.run) begin
      src_r <= RW'(cmd.item.src_row);
      src_c <= CW'(cmd.item.src_col);
      dst_r <= RW'(cmd.item.dst_row);
      dst_c <= CW'(cmd.item.dst_col);
    end
    if (state == ST_NRD) begin
      naddr <= nb_addr;
    end
  end

  // Result: reachable if the endpoints lie in the area and the destination was visited, distance saturated.
  always_comb begin
    status.busy             = (state != ST_IDLE);
    status.done             = (state == ST_FIN) && !res_full;
    status.result.reachable = !bad && ds_rd[DW];
    status.result.distance  = '0;
    if (status.result.reachable) begin
      if (32'(ds_rd[DW-1:0]) > gbfs_pkg::DIST_MAX) begin
        status.result.distance = gbfs_pkg::DIST_W'(gbfs_pkg::DIST_MAX);
      end else begin
        status.result.distance = gbfs_pkg::DIST_W'(ds_rd[DW-1:0]);
      end
    end
  end

endmodule

### design/grid_bfs_shortest_path_core.sv
// ----------------------------------------------------------------------------
// grid_bfs_shortest_path_core: shortest path over a binary maze
// Load words write one maze cell each. A solve word runs a breadth-first
// search over 4-connected open cells and returns one result word. A solve
// first clears the distance store, one entry a cycle, over all MAX_ROWS *
// 2^ceil(log2(MAX_COLS)) entries (4096 with the defaults); the search then
// seeds the queue with the source, dequeues one cell at a time and tests its
// four neighbours in turn: one inside the area is read from the maze and
// distance stores and then checked, one outside it is skipped. The single
// read port of the distance store keeps neighbours one at a time; the
// destination's distance is read last. A solve whose source or destination
// lies outside the configured area skips clear and search. A finished result
// is held in an output register, so the next word is taken while it waits.
// ----------------------------------------------------------------------------
module grid_bfs_shortest_path_core #(
  parameter int MAX_ROWS = gbfs_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = gbfs_pkg::MAX_COLS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  gbfs_pkg::gbfs_item_t              item,
  output logic                              result_valid,
  input  logic                              result_stall,
  output gbfs_pkg::gbfs_result_t            result,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [gbfs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gbfs_pkg::SIZE_W-1:0]       cfg_data
);

  logic [gbfs_pkg::SIZE_W-1:0] rows, cols;
  gbfs_pkg::gbfs_cmd_t         cmd;
  gbfs_pkg::gbfs_status_t      status;
  logic                        item_take;
  logic                        res_full;

  // Size registers; writes to unknown indexes are ignored.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows <= gbfs_pkg::SIZE_RESET;
      cols <= gbfs_pkg::SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        gbfs_pkg::REG_ROWS: rows <= cfg_data;
        gbfs_pkg::REG_COLS: cols <= cfg_data;
        default: begin
          rows <= rows;
        end
      endcase
    end
  end

  // Input handshake: a word is taken whenever the engine is idle.
  assign item_stall = status.busy;
  assign item_take  = item_valid && !item_stall;

  always_comb begin
    cmd.load  = item_take && (item.operation == gbfs_pkg::OP_LOAD);
    cmd.run   = item_take && (item.operation == gbfs_pkg::OP_SOLVE);
    cmd.item  = item;
    cmd.rows  = rows;
    cmd.cols  = cols;
  end

  // The output register is full while a result waits and is not being taken.
  assign res_full = result_valid && result_stall;

  gbfs_engine #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .res_full (res_full),
    .status   (status)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= status.done || res_full;
    end
  end

  always_ff @(posedge clk) begin
    if (status.done) begin
      result <= status.result;
    end
  end

endmodule

### design/gbfs_checker.sv
// ----------------------------------------------------------------------------
// gbfs_checker: port-level checks of the grid path search core
// Watches the channels of the top level and flags timing or value slips.
// ----------------------------------------------------------------------------
module gbfs_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   item_valid,
  input logic                   item_stall,
  input gbfs_pkg::gbfs_item_t   item,
  input logic                   result_valid,
  input logic                   result_stall,
  input gbfs_pkg::gbfs_result_t result
);

  // A stalled result word stays on the port unchanged.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result word changed while stalled");

  // An unreachable destination reports a distance of zero.
  a_unreach_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.reachable |-> result.distance == '0)
    else $error("unreachable result with non-zero distance");

  // A load word does not occupy the engine, so the next word may follow at once.
  a_load_single: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && item.operation == gbfs_pkg::OP_LOAD |=> !item_stall)
    else $error("input stalled after a load word");

  // A solve word occupies the engine, so the next cycle stalls.
  a_solve_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && item.operation == gbfs_pkg::OP_SOLVE |=> item_stall)
    else $error("input not stalled after a solve word");

  // No result is shown straight after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind grid_bfs_shortest_path_core gbfs_checker u_gbfs_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .item         (item),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
